// File: design/ktst_pkg.sv
// Package for the keyed text source tokenizer.
// Holds parse modes, event codes, character constants and sizing constants.
// No dependencies.
`timescale 1ns / 1ps

package ktst_pkg;

  // Sizing
  localparam int KEY_MAX_LEN = 8;   // key length that raises the error (2..15)
  localparam int CHAR_BYTES  = 2;   // text bytes per stored character (1..4)
  localparam int KEY_LEN_W   = 4;   // key length counter width, covers up to 15
  localparam int KEY_POS_W   = 3;   // reported key position width

  // Parse modes
  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_KEY     = 2'd1,
    MODE_VALUE   = 2'd2,
    MODE_COMMENT = 2'd3
  } mode_t;

  // Event codes carried on the result channel
  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_KEY_START  = 3'd1,
    EV_COMMIT_KEY = 3'd2,
    EV_KEY_CHAR   = 3'd3,
    EV_VALUE_CHAR = 3'd4,
    EV_KEY_END    = 3'd5,
    EV_TOO_LONG   = 3'd6
  } event_t;

  // Source characters
  localparam logic [7:0] CH_LBRACKET = 8'h5B;  // [
  localparam logic [7:0] CH_RBRACKET = 8'h5D;  // ]
  localparam logic [7:0] CH_LBRACE   = 8'h7B;  // {
  localparam logic [7:0] CH_RBRACE   = 8'h7D;  // }
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TAB      = 8'h09;

endpackage

// File: design/keyed_text_source_tokenizer_unit.sv
// Top level of the keyed text source tokenizer: parse state and result register.
// Depends on ktst_pkg.
`timescale 1ns / 1ps

// Takes one source byte per beat and returns one event beat per byte. Each
// byte is decoded combinationally against the parse state and its result is
// written to an output register, so a byte can be accepted every cycle; the
// only thing that throttles input is a held result (in_stall follows out_stall
// while a result is pending). The result beat appears in the cycle after its
// input beat is accepted. After a key-too-long error the block reports every
// further byte as a halted, empty event until reset.
module keyed_text_source_tokenizer_unit (
  input  logic        clk,
  input  logic        rst_n,
  // byte input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  // event output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_kind,
  output logic [7:0]  out_char_value,
  output logic [2:0]  out_key_position,
  output logic [31:0] out_text_offset,
  output logic [15:0] out_line_number,
  output logic [15:0] out_column_number,
  output logic        out_halted
);
  import ktst_pkg::*;

  // parse state
  mode_t                mode_r, mode_nxt;
  logic                 value_started_r, value_started_nxt;
  logic [KEY_LEN_W-1:0] key_len_r, key_len_nxt;
  logic [31:0]          offset_r, offset_nxt;
  logic [15:0]          row_r, row_nxt;
  logic [15:0]          col_r, col_nxt;
  logic                 error_r, error_nxt;

  // result register
  logic                 out_valid_r;
  event_t               ev_r, ev_nxt;
  logic [7:0]           char_r, char_nxt;
  logic [KEY_POS_W-1:0] pos_r, pos_nxt;
  logic [31:0]          toff_r;
  logic [15:0]          line_r, colout_r;
  logic                 halted_r;

  logic in_accept;
  logic vs;

  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // byte decode against current state
  always_comb begin
    mode_nxt          = mode_r;
    value_started_nxt = value_started_r;
    key_len_nxt       = key_len_r;
    offset_nxt        = offset_r;
    row_nxt           = row_r;
    col_nxt           = col_r;
    error_nxt         = error_r;
    ev_nxt            = EV_NONE;
    char_nxt          = 8'd0;
    pos_nxt           = '0;
    vs                = value_started_r;
    if (!error_r) begin
      if (in_byte == CH_LF) begin
        row_nxt = sat_inc(row_r);
        col_nxt = 16'd1;
      end else if (in_byte == CH_CR) begin
        col_nxt = sat_inc(col_r);
      end else if (in_byte == CH_LBRACKET && mode_r != MODE_COMMENT) begin
        // new key; a started value gets its terminator first
        if (value_started_r) begin
          offset_nxt = offset_r + 32'(CHAR_BYTES);
          ev_nxt     = EV_COMMIT_KEY;
        end else begin
          ev_nxt = EV_KEY_START;
        end
        mode_nxt    = MODE_KEY;
        key_len_nxt = '0;
        col_nxt     = sat_inc(col_r);
      end else if (in_byte == CH_LBRACE) begin
        mode_nxt = MODE_COMMENT;
        col_nxt  = sat_inc(col_r);
      end else begin
        case (mode_r)
          MODE_KEY: begin
            if (in_byte == CH_RBRACKET) begin
              mode_nxt          = MODE_VALUE;
              value_started_nxt = 1'b0;
              ev_nxt            = EV_KEY_END;
            end else begin
              char_nxt    = in_byte;
              pos_nxt     = key_len_r[KEY_POS_W-1:0];
              key_len_nxt = key_len_r + KEY_LEN_W'(1);
              if (key_len_nxt >= KEY_LEN_W'(KEY_MAX_LEN)) begin
                ev_nxt    = EV_TOO_LONG;
                error_nxt = 1'b1;
              end else begin
                ev_nxt = EV_KEY_CHAR;
              end
            end
          end
          MODE_VALUE: begin
            // leading blanks are dropped
            vs                = value_started_r | ~(in_byte inside {CH_SPACE, CH_TAB});
            value_started_nxt = vs;
            if (vs) begin
              char_nxt   = in_byte;
              offset_nxt = offset_r + 32'(CHAR_BYTES);
              ev_nxt     = EV_VALUE_CHAR;
            end
          end
          MODE_COMMENT: begin
            if (in_byte == CH_RBRACE) mode_nxt = MODE_VALUE;
          end
          default: ;
        endcase
        if (!error_nxt) col_nxt = sat_inc(col_r);
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= MODE_IDLE;
      value_started_r <= 1'b0;
      key_len_r       <= '0;
      offset_r        <= '0;
      row_r           <= 16'd1;
      col_r           <= 16'd1;
      error_r         <= 1'b0;
    end else if (in_accept) begin
      mode_r          <= mode_nxt;
      value_started_r <= value_started_nxt;
      key_len_r       <= key_len_nxt;
      offset_r        <= offset_nxt;
      row_r           <= row_nxt;
      col_r           <= col_nxt;
      error_r         <= error_nxt;
    end
  end

  // result beat valid and halted flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      halted_r    <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
      halted_r    <= error_nxt;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      ev_r     <= ev_nxt;
      char_r   <= char_nxt;
      pos_r    <= pos_nxt;
      toff_r   <= offset_nxt;
      line_r   <= row_r;
      colout_r <= col_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_kind    = ev_r;
  assign out_char_value    = char_r;
  assign out_key_position  = pos_r;
  assign out_text_offset   = toff_r;
  assign out_line_number   = line_r;
  assign out_column_number = colout_r;
  assign out_halted        = halted_r;

endmodule

// File: design/ktst_checker.sv
// Port-level checks for the keyed text source tokenizer, bound to its top level.
// Depends on ktst_pkg and keyed_text_source_tokenizer_unit.
`timescale 1ns / 1ps

module ktst_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_event_kind,
  input logic [7:0]  out_char_value,
  input logic [2:0]  out_key_position,
  input logic [15:0] out_line_number,
  input logic        out_halted
);
  import ktst_pkg::*;

  // a held result beat stays valid and keeps its event kind
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_kind))
    else $error("stalled result beat changed");

  // once halted, only halted beats follow until reset
  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_halted |=> out_halted)
    else $error("halted flag cleared without reset");

  // a halted beat is the error beat itself or an empty beat
  a_halt_ev: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_halted |->
      out_event_kind == EV_NONE || out_event_kind == EV_TOO_LONG)
    else $error("event reported while halted");

  // beats without a character carry zero char and position
  a_nochar: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == EV_NONE || out_event_kind == EV_KEY_START ||
                  out_event_kind == EV_COMMIT_KEY || out_event_kind == EV_KEY_END)
    |-> out_char_value == 8'd0 && out_key_position == 3'd0)
    else $error("stray character on a non-character beat");

  // row numbering starts at one and saturates
  a_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_line_number != 16'd0)
    else $error("line number zero");

endmodule

bind keyed_text_source_tokenizer_unit ktst_checker u_ktst_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_event_kind   (out_event_kind),
  .out_char_value   (out_char_value),
  .out_key_position (out_key_position),
  .out_line_number  (out_line_number),
  .out_halted       (out_halted)
);

// File: tb/sv/ktst_tb_pkg.sv
// Scoreboard for the keyed text source tokenizer testbench: token predictor and checker.
// Depends on ktst_pkg for parse modes, event codes, characters and sizing.
`timescale 1ns / 1ps

package ktst_tb_pkg;
  import ktst_pkg::*;

  // One result beat, laid out in port order
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  char_value;
    logic [2:0]  key_pos;
    logic [31:0] text_offset;
    logic [15:0] line;
    logic [15:0] column;
    logic        halted;
  } token_t;

  class token_checker;
    // Shadow parse state
    mode_t                mode;
    bit                   value_seen;
    logic [KEY_LEN_W-1:0] key_len;
    logic [31:0]          offset;
    logic [15:0]          row;
    logic [15:0]          col;
    bit                   stopped;

    token_t expected_tokens[$];
    int     errors;

    function new();
      mode       = MODE_IDLE;
      value_seen = 1'b0;
      key_len    = '0;
      offset     = '0;
      row        = 16'd1;
      col        = 16'd1;
      stopped    = 1'b0;
      errors     = 0;
    endfunction

    static function logic [15:0] bump(logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // Advance the shadow state by one accepted byte and queue its token
    function void note_byte(logic [7:0] b);
      token_t t;
      t        = '0;
      t.kind   = EV_NONE;
      t.line   = row;
      t.column = col;
      if (!stopped) begin
        if (b == CH_LF) begin
          row = bump(row);
          col = 16'd1;
        end else if (b == CH_CR) begin
          col = bump(col);
        end else if (b == CH_LBRACKET && mode != MODE_COMMENT) begin
          // a key opens; a seen value is committed with its terminator first
          if (value_seen) begin
            offset = offset + 32'(CHAR_BYTES);
            t.kind = EV_COMMIT_KEY;
          end else begin
            t.kind = EV_KEY_START;
          end
          mode    = MODE_KEY;
          key_len = '0;
          col     = bump(col);
        end else if (b == CH_LBRACE) begin
          mode = MODE_COMMENT;
          col  = bump(col);
        end else begin
          case (mode)
            MODE_KEY: begin
              if (b == CH_RBRACKET) begin
                mode       = MODE_VALUE;
                value_seen = 1'b0;
                t.kind     = EV_KEY_END;
              end else begin
                t.char_value = b;
                t.key_pos    = key_len[KEY_POS_W-1:0];
                key_len      = key_len + KEY_LEN_W'(1);
                if (key_len >= KEY_MAX_LEN) begin
                  t.kind  = EV_TOO_LONG;
                  stopped = 1'b1;
                end else begin
                  t.kind = EV_KEY_CHAR;
                end
              end
            end
            MODE_VALUE: begin
              // leading blanks are swallowed
              if (!value_seen && b != CH_SPACE && b != CH_TAB) value_seen = 1'b1;
              if (value_seen) begin
                t.char_value = b;
                offset       = offset + 32'(CHAR_BYTES);
                t.kind       = EV_VALUE_CHAR;
              end
            end
            MODE_COMMENT: begin
              if (b == CH_RBRACE) mode = MODE_VALUE;
            end
            default: ;
          endcase
          if (!stopped) col = bump(col);
        end
      end
      t.text_offset = offset;
      t.halted      = stopped;
      expected_tokens.push_back(t);
    endfunction

    function bit field_ok(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    // Compare one result beat against the oldest queued token
    function void check_result(token_t got);
      token_t exp;
      bit     ok;
      if (expected_tokens.size() == 0) begin
        $display("%0t: result beat with no byte pending, actual %0h", $time, got);
        errors++;
        return;
      end
      exp = expected_tokens.pop_front();
      ok  = 1'b1;
      ok  = field_ok("event_kind", exp.kind, got.kind) & ok;
      ok  = field_ok("char_value", exp.char_value, got.char_value) & ok;
      ok  = field_ok("key_position", exp.key_pos, got.key_pos) & ok;
      ok  = field_ok("text_offset", exp.text_offset, got.text_offset) & ok;
      ok  = field_ok("line_number", exp.line, got.line) & ok;
      ok  = field_ok("column_number", exp.column, got.column) & ok;
      ok  = field_ok("halted", exp.halted, got.halted) & ok;
      if (!ok) errors++;
    endfunction
  endclass

endpackage

// File: tb/sv/tb_keyed_text_source_tokenizer_unit.sv
// Testbench top for keyed_text_source_tokenizer_unit: drives byte beats, checks event beats.
// Depends on ktst_pkg, ktst_tb_pkg and the block itself.
`timescale 1ns / 1ps

module tb_keyed_text_source_tokenizer_unit;
  import ktst_pkg::*;
  import ktst_tb_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int RANDOM_ITEMS = 590;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_event_kind;
  logic [7:0]  out_char_value;
  logic [2:0]  out_key_position;
  logic [31:0] out_text_offset;
  logic [15:0] out_line_number;
  logic [15:0] out_column_number;
  logic        out_halted;

  token_t       result_beat;
  token_checker tok_chk;
  int           send_gap_pct;
  int           stall_pct;
  int           bytes_sent;
  int           idle_cycles;
  bit           allow_long_key;

  keyed_text_source_tokenizer_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte           (in_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_kind    (out_event_kind),
    .out_char_value    (out_char_value),
    .out_key_position  (out_key_position),
    .out_text_offset   (out_text_offset),
    .out_line_number   (out_line_number),
    .out_column_number (out_column_number),
    .out_halted        (out_halted)
  );

  assign result_beat = {out_event_kind, out_char_value, out_key_position, out_text_offset,
                        out_line_number, out_column_number, out_halted};

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side: check accepted beats, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tok_chk.check_result(result_beat);
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  // Watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic bit is_special(logic [7:0] b);
    return b == CH_LBRACKET || b == CH_RBRACKET || b == CH_LBRACE || b == CH_RBRACE ||
           b == CH_LF || b == CH_CR || b == CH_SPACE || b == CH_TAB;
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (is_special(b)) b = 8'($urandom_range(255));
    return b;
  endfunction

  function automatic logic [7:0] value_byte();
    case ($urandom_range(9))
      0:       return CH_RBRACKET;
      1:       return CH_RBRACE;
      2:       return CH_SPACE;
      3:       return CH_TAB;
      4:       return CH_CR;
      default: return plain_byte();
    endcase
  endfunction

  // Keep keys short of the error length until the halt test at the end
  function automatic logic [7:0] guard_byte(logic [7:0] b);
    if (!allow_long_key && tok_chk.mode == MODE_KEY && tok_chk.key_len >= KEY_MAX_LEN - 1 &&
        !(b == CH_RBRACKET || b == CH_LBRACKET || b == CH_LBRACE || b == CH_LF || b == CH_CR))
      return CH_RBRACKET;
    return b;
  endfunction

  // Present one byte beat, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] raw);
    logic [7:0] b;
    b = guard_byte(raw);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    tok_chk.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_comment();
    send_byte(CH_LBRACE);
    repeat ($urandom_range(6)) begin
      case ($urandom_range(5))
        0:       send_byte(CH_LBRACKET);
        1:       send_byte(CH_RBRACKET);
        2:       send_byte(CH_LF);
        default: send_byte(plain_byte());
      endcase
    end
    send_byte(CH_RBRACE);
  endtask

  // [key] value {comment} entry with random content, the key sometimes abandoned by a brace
  task automatic send_record();
    if ($urandom_range(3) == 0) send_byte(CH_LF);
    send_byte(CH_LBRACKET);
    repeat ($urandom_range(KEY_MAX_LEN - 1)) send_byte(plain_byte());
    if ($urandom_range(9) == 0) begin
      send_comment();  // key abandoned by a brace
    end else begin
      send_byte(CH_RBRACKET);
    end
    repeat ($urandom_range(3)) send_byte($urandom_range(1) ? CH_SPACE : CH_TAB);
    repeat ($urandom_range(10)) send_byte(value_byte());
    if ($urandom_range(3) == 0) send_comment();
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
  endtask

  task automatic send_random_items(input int n);
    int target;
    target = bytes_sent + n;
    while (bytes_sent < target) begin
      if ($urandom_range(99) < 85) send_record();
      else send_noise();
    end
  endtask

  initial begin
    // idle bytes, CR/LF, stray closers, keys, blanks, commit, abandoned key, comment
    logic [7:0] directed [24] = '{
      8'h78, CH_CR, CH_LF, CH_RBRACKET, CH_RBRACE, CH_LBRACKET, 8'h61, 8'h00,
      8'hFF, CH_RBRACKET, CH_SPACE, CH_TAB, 8'h76, CH_RBRACKET, CH_RBRACE, CH_SPACE,
      CH_LBRACKET, 8'h6B, CH_LBRACE, CH_LBRACKET, CH_RBRACE, 8'h77, CH_LBRACKET,
      CH_RBRACKET
    };
    tok_chk        = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_byte        = 8'h00;
    send_gap_pct   = 19;
    stall_pct      = 57;
    bytes_sent     = 0;
    allow_long_key = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_byte(directed[i]);
    send_random_items(RANDOM_ITEMS);

    send_gap_pct = 57;
    stall_pct    = 19;
    send_random_items(RANDOM_ITEMS);

    send_gap_pct = 0;
    stall_pct    = 0;
    send_random_items(RANDOM_ITEMS);

    // leave any comment so the next bracket really opens a key
    send_byte(CH_LBRACE);
    send_byte(CH_RBRACE);

    // key too long halts the block; later bytes must come back frozen
    allow_long_key = 1'b1;
    send_byte(CH_LBRACKET);
    repeat (KEY_MAX_LEN) send_byte(plain_byte());
    repeat (8) send_noise();
    in_valid <= 1'b0;

    while (tok_chk.expected_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (tok_chk.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
